// ----- design/adsr_env_pkg.sv -----
package adsr_env_pkg;

    // Field widths
    localparam int unsigned TIME_BITS  = 24;
    localparam int unsigned LEVEL_BITS = 15;

    // Product width: a tick count times a level
    localparam int unsigned NUM_W = TIME_BITS + LEVEL_BITS;

    // Configuration write port
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_TIME   = 3'd0,
        CFG_ATTACK_LEVEL  = 3'd1,
        CFG_DECAY_TIME    = 3'd2,
        CFG_SUSTAIN_LEVEL = 3'd3,
        CFG_RELEASE_TIME  = 3'd4
    } t_cfg_idx;

    // Reset values, cut to field width
    localparam logic [TIME_BITS-1:0]  ATTACK_TIME_RST   = TIME_BITS'(441);
    localparam logic [LEVEL_BITS-1:0] ATTACK_LEVEL_RST  = LEVEL_BITS'(32767);
    localparam logic [TIME_BITS-1:0]  DECAY_TIME_RST    = TIME_BITS'(4410);
    localparam logic [LEVEL_BITS-1:0] SUSTAIN_LEVEL_RST = LEVEL_BITS'(24576);
    localparam logic [TIME_BITS-1:0]  RELEASE_TIME_RST  = TIME_BITS'(4410);

    typedef struct packed {
        logic [TIME_BITS-1:0]  attack_time;
        logic [LEVEL_BITS-1:0] attack_level;
        logic [TIME_BITS-1:0]  decay_time;
        logic [LEVEL_BITS-1:0] sustain_level;
        logic [TIME_BITS-1:0]  release_time;
    } t_cfg;

    // Which part of the note a request falls in
    typedef enum logic [1:0] {
        MODE_ZERO  = 2'd0,  // negative release start, or past note end
        MODE_SHAPE = 2'd1,  // attack / decay / sustain
        MODE_REL   = 2'd2   // inside the release window
    } t_mode;

    // Sideband carried alongside a division
    typedef struct packed {
        t_mode                 mode;
        logic [TIME_BITS-1:0]  u;       // ticks left to note end
        logic [LEVEL_BITS-1:0] base;    // level the quotient is added to / taken from
        logic                  up;      // add quotient to base
        logic                  direct;  // base is the answer, quotient ignored
    } t_side;

endpackage

// ----- design/adsr_envelope_level_unit.sv -----
// Channel   Direction  Handshake              Payload
// request   in         i_valid / o_stall      i_elapsed_ticks, i_note_length
// result    out        o_valid / i_stall      o_env_level
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request accepted per cycle while o_stall is low; each gives one
// result, computed through the front end and the two bit-per-stage
// dividers (slope, then release scaling).
// Synchronous active-low reset clears valid bits and reloads the registers.
// A stalled result parks in a skid register; the pipeline halts only once
// that is full, and o_stall comes straight from it.
module adsr_envelope_level_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [adsr_env_pkg::TIME_BITS-1:0]  i_elapsed_ticks,
    input  logic [adsr_env_pkg::TIME_BITS-1:0]  i_note_length,
    // result
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [adsr_env_pkg::LEVEL_BITS-1:0] o_env_level,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [adsr_env_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adsr_env_pkg::CFG_W-1:0]      i_cfg_data
);
    import adsr_env_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes always taken; unknown indexes dropped.
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_time   <= ATTACK_TIME_RST;
            r_cfg.attack_level  <= ATTACK_LEVEL_RST;
            r_cfg.decay_time    <= DECAY_TIME_RST;
            r_cfg.sustain_level <= SUSTAIN_LEVEL_RST;
            r_cfg.release_time  <= RELEASE_TIME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ATTACK_TIME:   r_cfg.attack_time   <= i_cfg_data[TIME_BITS-1:0];
                CFG_ATTACK_LEVEL:  r_cfg.attack_level  <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_DECAY_TIME:    r_cfg.decay_time    <= i_cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_RELEASE_TIME:  r_cfg.release_time  <= i_cfg_data[TIME_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Whole pipeline moves together while the skid register is empty.
    // ------------------------------------------------------------------
    logic r_skid_vld;
    logic en;

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    // Front end: classify the request, set up the segment slope product
    logic                  fe_vld;
    logic [NUM_W-1:0]      fe_num;
    logic [TIME_BITS-1:0]  fe_den;
    t_side                 fe_side;

    adsr_env_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_note_length   (i_note_length),
        .i_cfg           (r_cfg),
        .o_valid         (fe_vld),
        .o_num           (fe_num),
        .o_den           (fe_den),
        .o_side          (fe_side)
    );

    // Slope division: segment offset * level span / segment length
    logic                  d1_vld;
    logic [LEVEL_BITS-1:0] d1_quot;
    t_side                 d1_side;

    adsr_env_div u_div_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fe_vld),
        .i_num   (fe_num),
        .i_den   (fe_den),
        .i_side  (fe_side),
        .o_valid (d1_vld),
        .o_quot  (d1_quot),
        .o_side  (d1_side)
    );

    // Shape level: base, or base moved by the quotient toward the target
    t_side r6_side;
    logic  r6_vld;
    t_side n6_side;

    always_comb begin
        n6_side = d1_side;
        if (!d1_side.direct) begin
            n6_side.base = d1_side.up ? (d1_side.base + d1_quot)
                                      : (d1_side.base - d1_quot);
        end
    end

    // Release product: shape level * ticks to note end
    logic [NUM_W-1:0] n7_num;
    logic [NUM_W-1:0] r7_num;
    t_side            r7_side;
    logic             r7_vld;

    assign n7_num = NUM_W'(r6_side.base) * NUM_W'(r6_side.u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= d1_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= n6_side;
            r7_num  <= n7_num;
            r7_side <= r6_side;
        end
    end

    // Release scaling: product / release time (only meaningful in release)
    logic                  d2_vld;
    logic [LEVEL_BITS-1:0] d2_quot;
    t_side                 d2_side;

    adsr_env_div u_div_release (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_num   (r7_num),
        .i_den   (r_cfg.release_time),
        .i_side  (r7_side),
        .o_valid (d2_vld),
        .o_quot  (d2_quot),
        .o_side  (d2_side)
    );

    // Final pick by note region
    logic [LEVEL_BITS-1:0] n_fin_lvl;

    always_comb begin
        case (d2_side.mode)
            MODE_SHAPE: n_fin_lvl = d2_side.base;
            MODE_REL:   n_fin_lvl = d2_quot;
            default:    n_fin_lvl = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register plus skid register
    // ------------------------------------------------------------------
    logic                  r_out_vld;
    logic [LEVEL_BITS-1:0] r_out_lvl;
    logic [LEVEL_BITS-1:0] r_skid_lvl;
    logic                  take;

    assign take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (en) begin
            if (d2_vld) begin
                if (!r_out_vld || take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (take) begin
                r_out_vld <= 1'b0;
            end
        end else if (take) begin
            // skid drains into the output register
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d2_vld) begin
                if (!r_out_vld || take) begin
                    r_out_lvl <= n_fin_lvl;
                end else begin
                    r_skid_lvl <= n_fin_lvl;
                end
            end
        end else if (take) begin
            r_out_lvl <= r_skid_lvl;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_env_level = r_out_lvl;

endmodule

// ----- design/adsr_env_div.sv -----
module adsr_env_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [adsr_env_pkg::NUM_W-1:0]     i_num,
    input  logic [adsr_env_pkg::TIME_BITS-1:0] i_den,
    input  adsr_env_pkg::t_side                i_side,
    output logic                               o_valid,
    output logic [adsr_env_pkg::LEVEL_BITS-1:0] o_quot,
    output adsr_env_pkg::t_side                o_side
);
    import adsr_env_pkg::*;

    // Restoring division, one quotient bit per stage, MSB first.
    // Callers guarantee num < den * 2**LEVEL_BITS.
    logic                  r_vld  [LEVEL_BITS];
    logic [LEVEL_BITS-1:0] r_quot [LEVEL_BITS];
    t_side                 r_side [LEVEL_BITS];
    logic [NUM_W-1:0]      r_rem  [LEVEL_BITS-1];
    logic [TIME_BITS-1:0]  r_den  [LEVEL_BITS-1];

    for (genvar k = 0; k < LEVEL_BITS; k++) begin : g_step
        localparam int unsigned SH = LEVEL_BITS - 1 - k;

        logic                  vld_in;
        logic [NUM_W-1:0]      rem_in;
        logic [TIME_BITS-1:0]  den_in;
        logic [LEVEL_BITS-1:0] quot_in;
        t_side                 side_in;
        logic [NUM_W-1:0]      n_sub;
        logic                  n_fits;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quot_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quot_in = r_quot[k-1];
            assign side_in = r_side[k-1];
        end

        assign n_sub  = NUM_W'(den_in) << SH;
        assign n_fits = rem_in >= n_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quot[k] <= quot_in | (n_fits ? (LEVEL_BITS'(1) << SH) : '0);
                r_side[k] <= side_in;
            end
        end

        if (k < LEVEL_BITS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_fits ? (rem_in - n_sub) : rem_in;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_valid = r_vld[LEVEL_BITS-1];
    assign o_quot  = r_quot[LEVEL_BITS-1];
    assign o_side  = r_side[LEVEL_BITS-1];

endmodule

// ----- design/adsr_env_front.sv -----
module adsr_env_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [adsr_env_pkg::TIME_BITS-1:0] i_elapsed_ticks,
    input  logic [adsr_env_pkg::TIME_BITS-1:0] i_note_length,
    input  adsr_env_pkg::t_cfg                 i_cfg,
    output logic                               o_valid,
    output logic [adsr_env_pkg::NUM_W-1:0]     o_num,
    output logic [adsr_env_pkg::TIME_BITS-1:0] o_den,
    output adsr_env_pkg::t_side                o_side
);
    import adsr_env_pkg::*;

    // Stage 1: release start and ticks to note end
    logic [TIME_BITS:0]   n1_rs;
    logic [TIME_BITS:0]   n1_u;
    logic                 r1_vld;
    logic [TIME_BITS-1:0] r1_t;
    logic [TIME_BITS-1:0] r1_rs;
    logic [TIME_BITS-1:0] r1_u;
    logic                 r1_neg;
    logic                 r1_past;

    assign n1_rs = {1'b0, i_note_length} - {1'b0, i_cfg.release_time};
    assign n1_u  = {1'b0, i_note_length} - {1'b0, i_elapsed_ticks};

    // Stage 2: pick the time the shape is evaluated at
    logic                 n2_pre;
    t_mode                n2_mode;
    logic                 r2_vld;
    logic [TIME_BITS-1:0] r2_x;
    t_mode                r2_mode;
    logic [TIME_BITS-1:0] r2_u;

    assign n2_pre  = !r1_neg && (r1_t < r1_rs);
    assign n2_mode = n2_pre ? MODE_SHAPE : ((r1_neg || r1_past) ? MODE_ZERO : MODE_REL);

    // Stage 3: which segment of the shape
    logic [TIME_BITS:0]   n3_end;
    logic                 r3_vld;
    logic [TIME_BITS-1:0] r3_x;
    logic [TIME_BITS-1:0] r3_dx;
    logic                 r3_att;
    logic                 r3_dec;
    t_mode                r3_mode;
    logic [TIME_BITS-1:0] r3_u;

    assign n3_end = {1'b0, i_cfg.attack_time} + {1'b0, i_cfg.decay_time};

    // Stage 4: operands of the segment slope
    logic [TIME_BITS-1:0]  n4_m;
    logic [LEVEL_BITS-1:0] n4_k;
    logic [TIME_BITS-1:0]  n4_den;
    t_side                 n4_side;
    logic                  r4_vld;
    logic [TIME_BITS-1:0]  r4_m;
    logic [LEVEL_BITS-1:0] r4_k;
    logic [TIME_BITS-1:0]  r4_den;
    t_side                 r4_side;

    always_comb begin
        n4_m           = r3_x;
        n4_k           = i_cfg.attack_level;
        n4_den         = i_cfg.attack_time;
        n4_side.mode   = r3_mode;
        n4_side.u      = r3_u;
        n4_side.base   = '0;
        n4_side.up     = 1'b1;
        n4_side.direct = 1'b0;
        if (r3_att) begin
            // zero attack time: straight to the attack level
            if (i_cfg.attack_time == '0) begin
                n4_side.direct = 1'b1;
                n4_side.base   = i_cfg.attack_level;
            end
        end else if (r3_dec) begin
            n4_m         = r3_dx;
            n4_den       = i_cfg.decay_time;
            n4_side.base = i_cfg.attack_level;
            if (i_cfg.sustain_level >= i_cfg.attack_level) begin
                n4_k = i_cfg.sustain_level - i_cfg.attack_level;
            end else begin
                n4_side.up = 1'b0;
                n4_k       = i_cfg.attack_level - i_cfg.sustain_level;
            end
        end else begin
            n4_side.direct = 1'b1;
            n4_side.base   = i_cfg.sustain_level;
        end
    end

    // Stage 5: slope product
    logic [NUM_W-1:0]     n5_num;
    logic                 r5_vld;
    logic [NUM_W-1:0]     r5_num;
    logic [TIME_BITS-1:0] r5_den;
    t_side                r5_side;

    assign n5_num = NUM_W'(r4_m) * NUM_W'(r4_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t    <= i_elapsed_ticks;
            r1_rs   <= n1_rs[TIME_BITS-1:0];
            r1_neg  <= n1_rs[TIME_BITS];
            r1_u    <= n1_u[TIME_BITS-1:0];
            r1_past <= n1_u[TIME_BITS] || (n1_u[TIME_BITS-1:0] == '0);

            r2_x    <= n2_pre ? r1_t : r1_rs;
            r2_mode <= n2_mode;
            r2_u    <= r1_u;

            r3_x    <= r2_x;
            r3_dx   <= r2_x - i_cfg.attack_time;
            r3_att  <= r2_x <= i_cfg.attack_time;
            r3_dec  <= {1'b0, r2_x} <= n3_end;
            r3_mode <= r2_mode;
            r3_u    <= r2_u;

            r4_m    <= n4_m;
            r4_k    <= n4_k;
            r4_den  <= n4_den;
            r4_side <= n4_side;

            r5_num  <= n5_num;
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    assign o_valid = r5_vld;
    assign o_num   = r5_num;
    assign o_den   = r5_den;
    assign o_side  = r5_side;

endmodule

// ----- design/adsr_env_checker.sv -----
module adsr_env_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [adsr_env_pkg::LEVEL_BITS-1:0] o_env_level
);
    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_env_level))
        else $error("stalled result changed");

    // Reset empties the result side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result valid after reset");

    // Request side only backs up once a result has been held off
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("request stall without a held result");

    // Back-pressure persists until the held result is taken
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !(o_valid && !i_stall) |=> o_stall)
        else $error("request stall dropped with result still held");

endmodule

bind adsr_envelope_level_unit adsr_env_checker u_checker (.*);
